@@ sv/wcrs_pkg.sv @@
// shared types, constants and helper functions for the write-combining range splitter
// no dependencies; imported by every module of the block

package wcrs_pkg;

   // field widths
   localparam int ADDR_W     = 52;
   localparam int COUNT_W    = 32;
   localparam int PAGE_SHIFT = 12;
   localparam int PG_W       = ADDR_W - PAGE_SHIFT;
   localparam int LEN_PG_W   = COUNT_W - PAGE_SHIFT;
   localparam int SLOT_W     = 4;
   localparam int SLOT_BITS  = 16;
   localparam int STATUS_W   = 2;

   // limits of the splitter
   localparam int MAX_SLOTS   = 16;
   localparam int MAX_RANGES  = 6;
   localparam int SLOT_LIMIT  = (MAX_SLOTS < SLOT_BITS) ? MAX_SLOTS : SLOT_BITS;
   localparam int MADE_W      = $clog2(MAX_RANGES + 1);
   localparam int QUEUE_DEPTH = 2;

   // register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // physical address width handling
   localparam logic [5:0] PHYS_BITS_MIN     = 6'd32;
   localparam logic [5:0] PHYS_BITS_MAX     = 6'd52;
   localparam logic [5:0] PHYS_BITS_DEFAULT = 6'd36;

   // register reset values
   localparam logic [4:0]  SLOT_COUNT_RESET = 5'd8;
   localparam logic [15:0] PREOCC_RESET     = 16'h0000;
   localparam logic        ENABLE_RESET     = 1'b1;

   typedef enum logic [1:0] {
      REG_SLOT_COUNT = 2'd0,
      REG_PREOCC     = 2'd1,
      REG_PHYS_BITS  = 2'd2,
      REG_ENABLE     = 2'd3
   } reg_idx_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_FULL    = 2'd0,
      ST_BAD     = 2'd1,
      ST_OFF     = 2'd2,
      ST_PARTIAL = 2'd3
   } status_type;

   typedef enum logic {
      KIND_RANGE = 1'b0,
      KIND_FINAL = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CMD_RUN = 2'd0,
      CMD_BAD = 2'd1,
      CMD_OFF = 2'd2
   } cmd_class_type;

   typedef struct packed {
      logic [4:0]  slot_count;
      logic [15:0] preoccupied;
      logic [5:0]  phys_bits;
      logic        enabled;
   } cfg_type;

   // classified request, addresses and lengths in 4 KB pages
   typedef struct packed {
      cmd_class_type       cls;
      logic [PG_W-1:0]     base_pg;
      logic [LEN_PG_W-1:0] len_pg;
      logic [PG_W-1:0]     pmask_pg;
   } cmd_type;

   // lowest set bit as one-hot
   function automatic logic [LEN_PG_W-1:0] lsb_onehot(input logic [LEN_PG_W-1:0] x);
      lsb_onehot = x & (~x + 1'b1);
   endfunction

   // highest set bit as one-hot, via bit reversal
   function automatic logic [LEN_PG_W-1:0] msb_onehot(input logic [LEN_PG_W-1:0] x);
      logic [LEN_PG_W-1:0] rev;
      logic [LEN_PG_W-1:0] low;
      for (int i = 0; i < LEN_PG_W; i++) begin
         rev[i] = x[LEN_PG_W-1-i];
      end
      low = rev & (~rev + 1'b1);
      for (int i = 0; i < LEN_PG_W; i++) begin
         msb_onehot[i] = low[LEN_PG_W-1-i];
      end
   endfunction

endpackage

@@ sv/wcrs_csr.sv @@
// configuration registers behind the apb-style register port
// depends on wcrs_pkg

module wcrs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [wcrs_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [wcrs_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [wcrs_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output wcrs_pkg::cfg_type                cfg
);
   import wcrs_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign pready = 1'b1;
   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;

   // register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_SLOT_COUNT: cfg_in.slot_count  = pwdata[4:0];
            REG_PREOCC:     cfg_in.preoccupied = pwdata[15:0];
            REG_PHYS_BITS:  cfg_in.phys_bits   = pwdata[5:0];
            REG_ENABLE:     cfg_in.enabled     = pwdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_count  <= SLOT_COUNT_RESET;
         cfg_ff.preoccupied <= PREOCC_RESET;
         cfg_ff.phys_bits   <= PHYS_BITS_DEFAULT;
         cfg_ff.enabled     <= ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read
   always_comb begin
      unique case (idx)
         REG_SLOT_COUNT: prdata = CSR_DATA_W'(cfg_ff.slot_count);
         REG_PREOCC:     prdata = CSR_DATA_W'(cfg_ff.preoccupied);
         REG_PHYS_BITS:  prdata = CSR_DATA_W'(cfg_ff.phys_bits);
         REG_ENABLE:     prdata = CSR_DATA_W'(cfg_ff.enabled);
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/wcrs_front.sv @@
// request front end: checks and classifies a region request, builds the physical mask
// depends on wcrs_pkg; feeds wcrs_queue

module wcrs_front (
   input  wcrs_pkg::cfg_type                cfg,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [wcrs_pkg::ADDR_W-1:0]      req_base_addr,
   input  logic [wcrs_pkg::COUNT_W-1:0]     req_byte_count,
   input  logic                             q_full,
   output logic                             q_push,
   output wcrs_pkg::cmd_type                q_cmd
);
   import wcrs_pkg::*;

   logic [COUNT_W:0]  round_sum;
   logic [COUNT_W:0]  rounded;
   logic [ADDR_W:0]   end_addr;
   logic              beyond;
   logic              bad;
   logic              off;
   logic [5:0]        bits_eff;
   logic [5:0]        shamt;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // round the byte count up to whole pages
   assign round_sum = {1'b0, req_byte_count}
                    + {{(COUNT_W+1-PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};
   assign rounded   = {round_sum[COUNT_W:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

   // end of region must not pass the top of the address space
   assign end_addr = {1'b0, req_base_addr} + {{(ADDR_W-COUNT_W){1'b0}}, rounded};
   assign beyond   = end_addr[ADDR_W] && (end_addr[ADDR_W-1:0] != '0);

   // request checks
   assign bad = (req_base_addr == '0)
             || (req_byte_count[COUNT_W-1:PAGE_SHIFT] == '0)
             || (req_base_addr[PAGE_SHIFT-1:0] != '0)
             || rounded[COUNT_W]
             || beyond;
   assign off = !cfg.enabled || (cfg.slot_count == '0);

   // physical mask in pages, out-of-range widths fall back to the default
   assign bits_eff = (cfg.phys_bits < PHYS_BITS_MIN || cfg.phys_bits > PHYS_BITS_MAX)
                   ? PHYS_BITS_DEFAULT : cfg.phys_bits;
   assign shamt    = bits_eff - 6'(PAGE_SHIFT);

   always_comb begin
      if (bad) begin
         q_cmd.cls = CMD_BAD;
      end else if (off) begin
         q_cmd.cls = CMD_OFF;
      end else begin
         q_cmd.cls = CMD_RUN;
      end
      q_cmd.base_pg  = req_base_addr[ADDR_W-1:PAGE_SHIFT];
      q_cmd.len_pg   = rounded[COUNT_W-1:PAGE_SHIFT];
      q_cmd.pmask_pg = ~({PG_W{1'b1}} << shamt);
   end

endmodule

@@ sv/wcrs_queue.sv @@
// short command queue between front end and range sequencer
// depends on wcrs_pkg

module wcrs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wcrs_pkg::cmd_type cmd_in,
   input  logic              pop,
   output wcrs_pkg::cmd_type cmd_out,
   output logic              empty,
   output logic              full
);
   import wcrs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign cmd_out = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ sv/wcrs_back.sv @@
// range sequencer: walks free slots, picks aligned power-of-two chunks, emits results
// depends on wcrs_pkg; takes commands from wcrs_queue

module wcrs_back (
   input  logic                              clock,
   input  logic                              reset,
   input  wcrs_pkg::cfg_type                 cfg,
   input  logic                              q_empty,
   input  wcrs_pkg::cmd_type                 q_cmd,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_kind,
   output logic [wcrs_pkg::SLOT_W-1:0]       rsp_slot_index,
   output logic [wcrs_pkg::ADDR_W-1:0]       rsp_base_word,
   output logic [wcrs_pkg::ADDR_W-1:0]       rsp_mask_word,
   output logic [wcrs_pkg::COUNT_W-1:0]      rsp_covered_bytes,
   output logic [wcrs_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_last
);
   import wcrs_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_EMIT,
      S_FINAL
   } state_type;

   state_type             state_ff, state_in;
   cmd_class_type         cls_ff, cls_in;
   logic [PG_W-1:0]       cur_ff, cur_in;
   logic [PG_W-1:0]       pmask_ff, pmask_in;
   logic [LEN_PG_W-1:0]   left_ff, left_in;
   logic [LEN_PG_W-1:0]   covered_ff, covered_in;
   logic [MADE_W-1:0]     made_ff, made_in;
   logic [SLOT_BITS-1:0]  used_ff, used_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [LEN_PG_W-1:0]   chunk_ff, chunk_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [ADDR_W-1:0]     rsp_base_ff, rsp_base_in;
   logic [ADDR_W-1:0]     rsp_mask_ff, rsp_mask_in;
   logic [COUNT_W-1:0]    rsp_cov_ff, rsp_cov_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [SLOT_BITS-1:0]  busy;
   logic [4:0]            limit;
   logic [SLOT_BITS-1:0]  avail;
   logic [SLOT_BITS-1:0]  free_oh;
   logic [SLOT_W-1:0]     free_idx;
   logic                  found;
   logic [LEN_PG_W-1:0]   size_oh;
   logic [LEN_PG_W-1:0]   align_oh;
   logic [LEN_PG_W-1:0]   chunk_pick;
   logic [LEN_PG_W-1:0]   covered_next;
   logic                  out_free;

   // lowest free slot below the usable slot count
   assign busy  = used_ff | cfg.preoccupied;
   assign limit = (cfg.slot_count > 5'(SLOT_LIMIT)) ? 5'(SLOT_LIMIT) : cfg.slot_count;

   always_comb begin
      for (int i = 0; i < SLOT_BITS; i++) begin
         avail[i] = !busy[i] && (5'(i) < limit);
      end
      free_oh  = avail & (~avail + 1'b1);
      free_idx = '0;
      for (int i = 0; i < SLOT_BITS; i++) begin
         if (free_oh[i]) begin
            free_idx = free_idx | SLOT_W'(i);
         end
      end
      found = (avail != '0);
   end

   // chunk size: largest power of two within the rest and the base alignment
   assign size_oh    = msb_onehot(left_ff);
   assign align_oh   = lsb_onehot({1'b0, cur_ff[LEN_PG_W-2:0]})
                     | {(cur_ff[LEN_PG_W-2:0] == '0), {(LEN_PG_W-1){1'b0}}};
   assign chunk_pick = (size_oh < align_oh) ? size_oh : align_oh;

   assign covered_next = covered_ff + chunk_ff;
   assign out_free     = !rsp_valid_ff || rsp_ready;

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      cls_in        = cls_ff;
      cur_in        = cur_ff;
      pmask_in      = pmask_ff;
      left_in       = left_ff;
      covered_in    = covered_ff;
      made_in       = made_ff;
      used_in       = used_ff;
      slot_in       = slot_ff;
      chunk_in      = chunk_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_cov_in    = rsp_cov_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop      = 1'b1;
               cls_in     = q_cmd.cls;
               cur_in     = q_cmd.base_pg;
               left_in    = q_cmd.len_pg;
               pmask_in   = q_cmd.pmask_pg;
               covered_in = '0;
               made_in    = '0;
               state_in   = (q_cmd.cls == CMD_RUN) ? S_CALC : S_FINAL;
            end
         end
         S_CALC: begin
            if (left_ff == '0 || made_ff == MADE_W'(MAX_RANGES) || !found) begin
               state_in = S_FINAL;
            end else begin
               slot_in  = free_idx;
               chunk_in = chunk_pick;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_RANGE;
               rsp_slot_in   = slot_ff;
               rsp_base_in   = {cur_ff & pmask_ff, {(PAGE_SHIFT-1){1'b0}}, 1'b1};
               rsp_mask_in   = {pmask_ff & ~{{(PG_W-LEN_PG_W){1'b0}}, chunk_ff - 1'b1},
                                1'b1, {(PAGE_SHIFT-1){1'b0}}};
               rsp_cov_in    = {covered_next, {PAGE_SHIFT{1'b0}}};
               rsp_status_in = ST_FULL;
               rsp_last_in   = 1'b0;
               used_in       = used_ff | (SLOT_BITS'(1) << slot_ff);
               cur_in        = cur_ff + {{(PG_W-LEN_PG_W){1'b0}}, chunk_ff};
               left_in       = left_ff - chunk_ff;
               covered_in    = covered_next;
               made_in       = made_ff + 1'b1;
               state_in      = S_CALC;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FINAL;
               rsp_slot_in  = '0;
               rsp_base_in  = '0;
               rsp_mask_in  = '0;
               rsp_cov_in   = {covered_ff, {PAGE_SHIFT{1'b0}}};
               rsp_last_in  = 1'b1;
               unique case (cls_ff)
                  CMD_RUN: rsp_status_in = (left_ff == '0) ? ST_FULL : ST_PARTIAL;
                  CMD_OFF: rsp_status_in = ST_OFF;
                  default: rsp_status_in = ST_BAD;
               endcase
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      cls_ff        <= cls_in;
      cur_ff        <= cur_in;
      pmask_ff      <= pmask_in;
      left_ff       <= left_in;
      covered_ff    <= covered_in;
      slot_ff       <= slot_in;
      chunk_ff      <= chunk_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_cov_ff    <= rsp_cov_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         made_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         made_ff      <= made_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_base_word     = rsp_base_ff;
   assign rsp_mask_word     = rsp_mask_ff;
   assign rsp_covered_bytes = rsp_cov_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

   // range beats are never last and always carry full status
   a_range_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_RANGE) |-> (!rsp_last_ff && rsp_status_ff == ST_FULL))
      else $error("range beat with last or nonzero status");

   // slots once taken stay taken
   a_used_grows: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((used_ff & $past(used_ff)) == $past(used_ff)))
      else $error("used slot released");

   // never more chunks than the range limit
   a_made_limit: assert property (@(posedge clock) disable iff (reset)
      made_ff <= MADE_W'(MAX_RANGES))
      else $error("chunk count beyond range limit");

   // a chunk about to be emitted is a single power of two on a free slot
   a_emit_chunk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> ($onehot(chunk_ff) && !busy[slot_ff]))
      else $error("bad chunk or busy slot at emit");

endmodule

@@ sv/wc_range_splitter_core.sv @@
// Write-combining range splitter. A request (4 KB aligned base, byte count) is checked and
// classified combinationally and queued (two entries), so requests keep arriving while the
// sequencer works. The sequencer loads a request, then for each chunk picks the slot and
// chunk size and then writes the result, then makes the closing slot check and writes the
// final status beat, with at most six chunks per programmed request; a rejected or disabled
// request goes from loading straight to the final status beat. Each result write waits while
// the previous result is not yet taken. Slot use accumulates
// across requests and is cleared only by reset. Registers sit at byte offsets 0, 4, 8, 12.
// depends on wcrs_pkg, wcrs_csr, wcrs_front, wcrs_queue, wcrs_back

module wc_range_splitter_core (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [wcrs_pkg::ADDR_W-1:0]       req_base_addr,
   input  logic [wcrs_pkg::COUNT_W-1:0]      req_byte_count,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_kind,
   output logic [wcrs_pkg::SLOT_W-1:0]       rsp_slot_index,
   output logic [wcrs_pkg::ADDR_W-1:0]       rsp_base_word,
   output logic [wcrs_pkg::ADDR_W-1:0]       rsp_mask_word,
   output logic [wcrs_pkg::COUNT_W-1:0]      rsp_covered_bytes,
   output logic [wcrs_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_last,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wcrs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [wcrs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [wcrs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import wcrs_pkg::*;

   cfg_type cfg;
   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;

   // configuration registers
   wcrs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // request check and classification
   wcrs_front u_front (
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_base_addr  (req_base_addr),
      .req_byte_count (req_byte_count),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (push_cmd)
   );

   // command queue
   wcrs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .cmd_in  (push_cmd),
      .pop     (q_pop),
      .cmd_out (head_cmd),
      .empty   (q_empty),
      .full    (q_full)
   );

   // range sequencer and result register
   wcrs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_empty           (q_empty),
      .q_cmd             (head_cmd),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_base_word     (rsp_base_word),
      .rsp_mask_word     (rsp_mask_word),
      .rsp_covered_bytes (rsp_covered_bytes),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

endmodule

@@ test/wc_range_splitter_core_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for wc_range_splitter_core: directed and random region requests,
// every result beat checked against an in-bench prediction of the power-of-two range split
// depends on wcrs_pkg and wc_range_splitter_core

module wc_range_splitter_core_tb;
   import wcrs_pkg::*;

   localparam logic [63:0] PAGE_BYTES  = 64'h1000;
   localparam logic [63:0] ADDR_SPAN   = 64'h0010_0000_0000_0000;
   localparam logic [63:0] MASK_FULL52 = 64'h000F_FFFF_FFFF_F000;
   localparam logic [63:0] PAGE_ALIGN  = 64'hFFFF_FFFF_FFFF_F000;
   localparam logic [63:0] VALID_FLAG  = 64'h800;
   localparam logic [63:0] WC_MEMTYPE  = 64'h1;
   localparam int          IDLE_PCT    = 19;

   typedef struct packed {
      kind_type            kind;
      logic [SLOT_W-1:0]   slot;
      logic [ADDR_W-1:0]   base_word;
      logic [ADDR_W-1:0]   mask_word;
      logic [COUNT_W-1:0]  covered;
      status_type          status;
      logic                last;
   } beat_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ADDR_W-1:0]      req_base_addr = '0;
   logic [COUNT_W-1:0]     req_byte_count = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_kind;
   logic [SLOT_W-1:0]      rsp_slot_index;
   logic [ADDR_W-1:0]      rsp_base_word;
   logic [ADDR_W-1:0]      rsp_mask_word;
   logic [COUNT_W-1:0]     rsp_covered_bytes;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   rsp_last;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // predicted register contents and slot occupancy
   logic [4:0]             cfg_slot_count = 5'd8;
   logic [15:0]            cfg_preoccupied = 16'h0000;
   logic [5:0]             cfg_phys_bits = 6'd36;
   logic                   cfg_enabled = 1'b1;
   logic [15:0]            slots_taken = 16'h0000;

   beat_type               pending_beats[$];
   bit                     steady = 1'b0;
   int                     stall_request = 0;
   int                     stall_left = 0;
   int                     n_errors = 0;
   int                     n_requests = 0;
   int                     n_beats = 0;
   int                     n_range_beats = 0;
   int                     n_reg_writes = 0;

   wc_range_splitter_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_base_addr     (req_base_addr),
      .req_byte_count    (req_byte_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_base_word     (rsp_base_word),
      .rsp_mask_word     (rsp_mask_word),
      .rsp_covered_bytes (rsp_covered_bytes),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // clock and run limit
   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("run limit reached with %0d beats outstanding", pending_beats.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // closing status beat of a request
   function automatic void push_final(input logic [COUNT_W-1:0] covered, input status_type st);
      beat_type b;
      b = '0;
      b.kind    = KIND_FINAL;
      b.covered = covered;
      b.status  = st;
      b.last    = 1'b1;
      pending_beats.push_back(b);
   endfunction

   // expected beats of one region request; claims slots as the block does
   function automatic void split_region(input logic [ADDR_W-1:0] base,
                                        input logic [COUNT_W-1:0] count);
      logic [63:0] rounded;
      logic [63:0] pmask;
      logic [63:0] cur;
      logic [63:0] chunk;
      logic [63:0] bw;
      logic [63:0] mw;
      logic [31:0] left;
      logic [15:0] busy;
      logic [5:0]  bits;
      int          slot_lim;
      int          slot;
      int          made;
      beat_type    b;
      rounded = ({32'd0, count} + 64'hFFF) & PAGE_ALIGN;
      // rejections are checked before anything else
      if (base == '0 || count < 32'h1000 || base[11:0] != 12'h000 ||
          rounded > 64'hFFFF_FFFF || {12'd0, base} + rounded > ADDR_SPAN) begin
         push_final('0, ST_BAD);
         return;
      end
      if (!cfg_enabled || cfg_slot_count == 5'd0) begin
         push_final('0, ST_OFF);
         return;
      end
      // out-of-range widths fall back to 36 bits
      bits = cfg_phys_bits;
      if (bits < 6'd32 || bits > 6'd52) bits = 6'd36;
      if (bits == 6'd52) pmask = MASK_FULL52;
      else pmask = ((64'd1 << bits) - 64'd1) & PAGE_ALIGN;
      slot_lim = cfg_slot_count;
      if (slot_lim > 16) slot_lim = 16;
      if (slot_lim > MAX_SLOTS) slot_lim = MAX_SLOTS;
      left = rounded[31:0];
      cur  = {12'd0, base};
      made = 0;
      while (left != 32'd0 && made < MAX_RANGES) begin
         busy = slots_taken | cfg_preoccupied;
         slot = -1;
         for (int i = slot_lim - 1; i >= 0; i--) begin
            if (!busy[i]) slot = i;
         end
         if (slot < 0) break;
         // largest power of two that fits and is naturally aligned at cur
         chunk = 64'd1;
         while (chunk < 64'h8000_0000 && (chunk << 1) <= {32'd0, left}) chunk = chunk << 1;
         while (chunk > PAGE_BYTES && (cur & (chunk - 64'd1)) != 64'd0) chunk = chunk >> 1;
         if (chunk < PAGE_BYTES) chunk = PAGE_BYTES;
         slots_taken[slot] = 1'b1;
         bw = (cur & pmask) | WC_MEMTYPE;
         mw = (pmask & ~(chunk - 64'd1)) | VALID_FLAG;
         cur  = cur + chunk;
         left = left - chunk[31:0];
         b = '0;
         b.kind      = KIND_RANGE;
         b.slot      = slot[SLOT_W-1:0];
         b.base_word = bw[ADDR_W-1:0];
         b.mask_word = mw[ADDR_W-1:0];
         b.covered   = rounded[31:0] - left;
         b.status    = ST_FULL;
         b.last      = 1'b0;
         pending_beats.push_back(b);
         made++;
      end
      if (left == 32'd0) push_final(rounded[31:0] - left, ST_FULL);
      else push_final(rounded[31:0] - left, ST_PARTIAL);
   endfunction

   // one request beat, with a random gap ahead of it
   task automatic send_region(input logic [ADDR_W-1:0] base, input logic [COUNT_W-1:0] count);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, 5);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_base_addr  <= base;
      req_byte_count <= count;
      do @(posedge clock); while (!req_ready);
      split_region(base, count);
      n_requests++;
   endtask

   // drop valid and wait until every expected beat has come back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
   endtask

   // register write: setup cycle, then access cycle
   task automatic write_reg(input reg_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_SLOT_COUNT: cfg_slot_count  = value[4:0];
         REG_PREOCC:     cfg_preoccupied = value[15:0];
         REG_PHYS_BITS:  cfg_phys_bits   = value[5:0];
         REG_ENABLE:     cfg_enabled     = value[0];
         default: ;
      endcase
      n_reg_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // random request: mostly well formed, the rest raw noise
   task automatic send_random_region(input bit well_formed);
      logic [63:0]        raw;
      logic [ADDR_W-1:0]  base;
      logic [COUNT_W-1:0] count;
      raw   = {$urandom, $urandom};
      count = $urandom;
      if (well_formed) begin
         count = count >> $urandom_range(0, 19);
         if (count < 32'h1000) count = count | 32'h1000;
         if (count > 32'hFFFF_F000) count = 32'hFFFF_F000;
         raw  = raw >> $urandom_range(0, 40);
         base = raw[ADDR_W-1:0];
         base[11:0] = 12'h000;
         if ({12'd0, base} + {32'd0, count} + PAGE_BYTES > ADDR_SPAN) base[51:44] = 8'h00;
         if (base == '0) base = 52'h1000 << $urandom_range(0, 20);
      end else begin
         base = raw[ADDR_W-1:0];
         if ($urandom_range(1) == 0) base[11:0] = 12'h000;
         if ($urandom_range(1) == 0) count = count >> $urandom_range(0, 31);
      end
      send_region(base, count);
   endtask

   // result channel: random idling, plus a long hold when a test asks for one
   always @(negedge clock) begin
      if (stall_request != 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!steady && $urandom_range(99) < IDLE_PCT) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         n_errors++;
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endfunction

   // compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_beats++;
         if (pending_beats.size() == 0) begin
            n_errors++;
            $display("%0t ns: unexpected beat, expected none, got kind %0d status %0d cov 0x%0h",
                     $time, rsp_kind, rsp_status, rsp_covered_bytes);
         end else begin
            want = pending_beats.pop_front();
            if (want.kind == KIND_RANGE) n_range_beats++;
            check_field("kind", want.kind, rsp_kind);
            check_field("slot_index", want.slot, rsp_slot_index);
            check_field("base_word", want.base_word, rsp_base_word);
            check_field("mask_word", want.mask_word, rsp_mask_word);
            check_field("covered_bytes", want.covered, rsp_covered_bytes);
            check_field("status", want.status, rsp_status);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // malformed requests under reset settings, no slot is touched
   task automatic test_bad_requests();
      send_region(52'h0, 32'h1000);
      send_region(52'h1000, 32'h0);
      send_region(52'h1000, 32'hFFF);
      send_region(52'h1001, 32'h1000);
      send_region(52'h800, 32'h1000);
      send_region(52'hF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_region(52'h2000, 32'hFFFF_F001);
      send_region(52'hF_FFFF_FFFF_F000, 32'h2000);
      settle();
   endtask

   // feature off and zero slots, bad request still wins over disabled
   task automatic test_disabled();
      write_reg(REG_ENABLE, 32'd0);
      send_region(52'h10000, 32'h10000);
      send_region(52'h10010, 32'h10000);
      settle();
      write_reg(REG_ENABLE, 32'd1);
      write_reg(REG_SLOT_COUNT, 32'd0);
      send_region(52'h10000, 32'h10000);
      settle();
      write_reg(REG_SLOT_COUNT, 32'd8);
   endtask

   // all slots held elsewhere, then lowest free slot with gaps in the map
   task automatic test_slot_choice();
      write_reg(REG_PREOCC, 32'hFFFF);
      send_region(52'h40000, 32'h4000);
      settle();
      write_reg(REG_PREOCC, 32'h00F5);
      // rounds up to 28 KB: 4 KB in slot 1, 8 KB in slot 3, then out of slots
      send_region(52'h1000, 32'h6001);
      settle();
   endtask

   // largest count, cut off after the chunk limit; slot count above 16 is clamped
   task automatic test_range_limit();
      write_reg(REG_SLOT_COUNT, 32'd31);
      write_reg(REG_PREOCC, 32'hFE00);
      send_region(52'h1000, 32'hFFFF_F000);
      settle();
   endtask

   // base and mask words at narrow, full and out-of-range address widths
   task automatic test_address_width();
      write_reg(REG_PREOCC, 32'h0000);
      write_reg(REG_SLOT_COUNT, 32'd16);
      write_reg(REG_PHYS_BITS, 32'd32);
      send_region(52'h1_2345_6000, 32'h2000);
      settle();
      write_reg(REG_PHYS_BITS, 32'd52);
      // ends exactly at the top of the address space
      send_region(52'hF_FFFF_FFFF_E000, 32'h1800);
      settle();
      write_reg(REG_PHYS_BITS, 32'd63);
      send_region(52'h10_0000_0000, 32'h1000);
      settle();
   endtask

   // random phases, each under its own register settings
   task automatic test_random_traffic();
      logic [4:0]  slots;
      logic [15:0] preocc;
      logic [5:0]  bits;
      logic        enable;
      for (int phase = 0; phase < 8; phase++) begin
         settle();
         preocc = 16'($urandom_range(16'hFFFF));
         enable = 1'b1;
         case (phase)
            0: begin slots = 5'd16; bits = 6'd32; preocc = 16'hFFFF; end
            1: begin slots = 5'd31; bits = 6'd52; end
            2: begin slots = 5'd1;  bits = 6'd0;  enable = 1'b0; end
            3: begin slots = 5'd0;  bits = 6'd36; end
            4: begin slots = 5'd12; bits = 6'd44; end
            5: begin slots = 5'd17; bits = 6'd31; end
            6: begin slots = 5'd8;  bits = 6'd53; end
            default: begin slots = 5'd16; bits = 6'd36; preocc = 16'h0000; end
         endcase
         write_reg(REG_SLOT_COUNT, {27'd0, slots});
         write_reg(REG_PREOCC, {16'd0, preocc});
         write_reg(REG_PHYS_BITS, {26'd0, bits});
         write_reg(REG_ENABLE, {31'd0, enable});
         // one phase runs with no idling on either side
         steady = (phase == 5);
         repeat (42) send_random_region($urandom_range(99) < 75);
      end
      settle();
      steady = 1'b0;
   endtask

   // receiver holds off long while requests keep coming, so the input stalls
   task automatic test_backpressure();
      settle();
      stall_request = 250;
      repeat (16) send_random_region(1'b1);
      settle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_bad_requests();
      test_disabled();
      test_slot_choice();
      test_range_limit();
      test_address_width();
      test_random_traffic();
      test_backpressure();
      settle();
      repeat (20) @(posedge clock);
      $display("%0d requests, %0d result beats checked (%0d range beats), %0d register writes",
               n_requests, n_beats, n_range_beats, n_reg_writes);
      $display("rejections, disabled, busy slots, chunk limit, address widths, long result hold");
      if (n_errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
